// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on the rising edge of aclk, held off while aresetn is low.
`define LSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Same, with clock and reset named by the caller.
`define LSS_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`endif

// ===== rtl/core/lss_pkg.sv =====
// Package for the LIFO stack with search: codes, cell link and control types.
package lss_pkg;

    localparam int DEPTH_DEF = 64;

    localparam int OP_W   = 3;
    localparam int DATA_W = 8;
    localparam int FLD_W  = 7;
    localparam int STAT_W = 2;

    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_POP    = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef enum logic [2:0] {
        CC_HOLD,
        CC_PUSH,
        CC_POP,
        CC_CLEAR,
        CC_LOAD,
        CC_SHIFT
    } cell_cmd_t;

    // Broadcast to every cell.
    typedef struct packed {
        cell_cmd_t         cmd;
        logic [DATA_W-1:0] key;
    } cell_ctrl_t;

    // What one cell shows its neighbours.
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              valid;
        logic              hit;
    } cell_link_t;

endpackage

// ===== rtl/core/lss_cell.sv =====
// One stack cell: an entry, its valid flag and a search hit flag.
module lss_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  lss_pkg::cell_ctrl_t ctrl,
    input  lss_pkg::cell_link_t up,
    input  lss_pkg::cell_link_t dn,
    output lss_pkg::cell_link_t cur
);

    logic [lss_pkg::DATA_W-1:0] data_reg;
    logic                       valid_reg;
    logic                       hit_reg;

    // payload, no reset
    always_ff @(posedge aclk) begin
        unique case (ctrl.cmd)
            lss_pkg::CC_PUSH: data_reg <= up.data;
            lss_pkg::CC_POP:  data_reg <= dn.data;
            default:          data_reg <= data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end else begin
            unique case (ctrl.cmd)
                lss_pkg::CC_PUSH:  valid_reg <= up.valid;
                lss_pkg::CC_POP:   valid_reg <= dn.valid;
                lss_pkg::CC_CLEAR: valid_reg <= 1'b0;
                default:           valid_reg <= valid_reg;
            endcase
            unique case (ctrl.cmd)
                lss_pkg::CC_LOAD:  hit_reg <= valid_reg && (data_reg == ctrl.key);
                lss_pkg::CC_SHIFT: hit_reg <= dn.hit;
                default:           hit_reg <= hit_reg;
            endcase
        end
    end

    assign cur = '{data: data_reg, valid: valid_reg, hit: hit_reg};

endmodule

// ===== rtl/core/lifo_stack_with_search_top.sv =====
// LIFO stack with search: a chain of shifting cells, cell 0 holding the top entry.
// Push, pop, peek, clear and undefined codes: result registered in the cycle after the item.
// Search: compare flags are latched, then shift towards the top one cell a cycle while
// the output register is free; result: hit position (1 = top), else status EMPTY, position 0.
// One item at a time; a new item is taken only outside a search, with the output register free.
// Synchronous active-low reset empties the stack; entry bytes are not cleared.
`include "assert_macros.svh"

module lifo_stack_with_search_top #(
    parameter int DEPTH = lss_pkg::DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] value
    input  logic [2:0]  s_tuser,   // [2:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [1:0] status, [9:2] data_out, [16:10] position,
                                   // [23:17] count, [24] is_empty, [31:25] zero
);

    localparam int CntW = $clog2(DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t                      state_reg, state_next;
    logic [CntW-1:0]             count_reg, count_next;
    logic [CntW-1:0]             step_reg, step_next;
    logic                        m_valid_reg;
    logic [31:0]                 m_data_reg;

    lss_pkg::cell_ctrl_t         ctrl;
    lss_pkg::cell_link_t         links [DEPTH];

    logic                        s_acc;
    logic                        out_free;
    logic                        res_load;
    logic [lss_pkg::STAT_W-1:0]  res_status;
    logic [lss_pkg::DATA_W-1:0]  res_data;
    logic [CntW-1:0]             res_pos;
    logic [CntW+lss_pkg::FLD_W-1:0] pos_ext, cnt_ext;
    logic                        is_full;
    logic                        pop_ok;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign s_acc    = s_tvalid && s_tready;
    assign is_full  = (count_reg == CntW'(DEPTH));
    assign pop_ok   = s_acc && (s_tuser == lss_pkg::OP_POP) && (count_reg != '0);

    // ---- cell chain ----
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        lss_pkg::cell_link_t up_w, dn_w;
        if (i == 0) begin : g_top
            assign up_w = '{data: s_tdata, valid: 1'b1, hit: 1'b0};
        end else begin : g_up
            assign up_w = links[i-1];
        end
        if (i == DEPTH - 1) begin : g_bot
            assign dn_w = '{data: '0, valid: 1'b0, hit: 1'b0};
        end else begin : g_dn
            assign dn_w = links[i+1];
        end
        lss_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .up      (up_w),
            .dn      (dn_w),
            .cur     (links[i])
        );
    end

    // ---- control ----
    always_comb begin
        ctrl.cmd   = lss_pkg::CC_HOLD;
        ctrl.key   = s_tdata;
        state_next = state_reg;
        count_next = count_reg;
        step_next  = step_reg;
        res_load   = 1'b0;
        res_status = lss_pkg::STAT_OK;
        res_data   = '0;
        res_pos    = '0;
        if (s_acc) begin
            res_load = 1'b1;
            unique case (s_tuser)
                lss_pkg::OP_PUSH: begin
                    if (is_full) begin
                        res_status = lss_pkg::STAT_FULL;
                    end else begin
                        ctrl.cmd   = lss_pkg::CC_PUSH;
                        count_next = count_reg + 1'b1;
                    end
                end
                lss_pkg::OP_POP: begin
                    if (count_reg == '0) begin
                        res_status = lss_pkg::STAT_EMPTY;
                    end else begin
                        ctrl.cmd   = lss_pkg::CC_POP;
                        res_data   = links[0].data;
                        count_next = count_reg - 1'b1;
                    end
                end
                lss_pkg::OP_PEEK: begin
                    if (count_reg == '0) begin
                        res_status = lss_pkg::STAT_EMPTY;
                    end else begin
                        res_data = links[0].data;
                    end
                end
                lss_pkg::OP_CLEAR: begin
                    ctrl.cmd   = lss_pkg::CC_CLEAR;
                    count_next = '0;
                end
                lss_pkg::OP_SEARCH: begin
                    if (count_reg == '0) begin
                        res_status = lss_pkg::STAT_EMPTY;
                    end else begin
                        // latch compare flags, result comes from the scan
                        res_load   = 1'b0;
                        ctrl.cmd   = lss_pkg::CC_LOAD;
                        state_next = S_SCAN;
                        step_next  = '0;
                    end
                end
                default: ;
            endcase
        end else if (state_reg == S_SCAN && out_free) begin
            if (links[0].hit) begin
                res_load   = 1'b1;
                res_pos    = step_reg + 1'b1;
                state_next = S_IDLE;
            end else if (step_reg + 1'b1 == count_reg) begin
                res_load   = 1'b1;
                res_status = lss_pkg::STAT_EMPTY;
                state_next = S_IDLE;
            end else begin
                ctrl.cmd  = lss_pkg::CC_SHIFT;
                step_next = step_reg + 1'b1;
            end
        end
    end

    // 7-bit output fields, masked as wide depths require
    assign pos_ext = {{lss_pkg::FLD_W{1'b0}}, res_pos};
    assign cnt_ext = {{lss_pkg::FLD_W{1'b0}}, count_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            if (res_load) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= {7'd0, (count_next == '0), cnt_ext[lss_pkg::FLD_W-1:0],
                                pos_ext[lss_pkg::FLD_W-1:0], res_data, res_status};
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ---- checks ----
    `LSS_ASSERT(a_count_bound, count_reg <= CntW'(DEPTH), "count above depth")
    `LSS_ASSERT(a_top_valid, links[0].valid == (count_reg != '0), "top valid vs count")
    `LSS_ASSERT(a_bot_valid, links[DEPTH-1].valid == is_full, "bottom valid vs full")
    `LSS_ASSERT(a_pop_count, pop_ok |=> count_reg == $past(count_reg) - 1'b1, "pop count")
    `LSS_ASSERT(a_scan_bound, state_reg == S_SCAN |-> step_reg < count_reg, "scan past count")

endmodule
